/* design/ils_pkg.sv */
// ----------------------------------------------------------------------------
// ils_pkg
// Types and codes shared by the indexed list store and its storage cells.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned SlotW = 9;

  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_PUSH    = 3'd2;
  localparam logic [2:0] CMD_GET     = 3'd3;
  localparam logic [2:0] CMD_REPLACE = 3'd4;
  localparam logic [2:0] CMD_POP     = 3'd5;
  localparam logic [2:0] CMD_REMOVE  = 3'd6;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_INDEX = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;
  localparam logic [1:0] ERR_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  position;
    logic [31:0] item_value;
  } ils_in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [4:0]  new_length;
    logic [1:0]  error_code;
  } ils_out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE,
    CELL_WRITE
  } ils_cell_op_e;

  typedef struct packed {
    ils_cell_op_e     op;
    logic [SlotW-1:0] slot;
  } ils_cell_ctl_t;

endpackage

/* design/ils_cell.sv */
// ----------------------------------------------------------------------------
// ils_cell
// One list entry: holds, loads, or takes its left or right neighbor's word.
// ----------------------------------------------------------------------------
module ils_cell import ils_pkg::*; #(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  ils_cell_ctl_t        ctl_i,
  input  logic [WORD_BITS-1:0] item_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  output logic [WORD_BITS-1:0] word_o,
  output logic [WORD_BITS-1:0] rd_o
);

  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 hit;
  logic                 above;

  assign hit   = (ctl_i.slot == SlotW'(INDEX));
  assign above = (ctl_i.slot < SlotW'(INDEX));

  always_comb begin
    word_d = word_q;
    unique case (ctl_i.op)
      CELL_OPEN: begin
        if (above) begin
          word_d = left_i;
        end else if (hit) begin
          word_d = item_i;
        end
      end
      CELL_CLOSE: begin
        if (above || hit) begin
          word_d = right_i;
        end
      end
      CELL_WRITE: begin
        if (hit) begin
          word_d = item_i;
        end
      end
      default: begin
        word_d = word_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign rd_o   = hit ? word_q : '0;

endmodule

/* design/indexed_list_store.sv */
// ----------------------------------------------------------------------------
// indexed_list_store
// Fixed-capacity ordered list of words kept in a row of shifting cells.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_data_i  (ils_in_t)
//   out      output     out_valid_o / out_ready_i out_data_o (ils_out_t)
//
// One command per cycle unless a held result stalls input: every cell shifts,
// loads or holds on the edge that takes a command, which also registers its result.
// The read path is an AND-OR over all cells, selected by slot.
// Reset clears the length and the output valid; entry words are not cleared.
// A waiting result stalls input only when the output is not taken that cycle.
// ----------------------------------------------------------------------------
module indexed_list_store import ils_pkg::*; #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ils_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ils_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [SlotW-1:0] CapSlot = SlotW'(CAPACITY);

  logic [CntW-1:0]      count_q, count_d, count_n;
  logic                 out_valid_q, out_valid_d;
  ils_out_t             out_q, out_d;
  logic                 fire;
  ils_cell_ctl_t        ctl;
  logic [1:0]           err;
  logic                 rd_en;
  logic [SlotW-1:0]     pos_s, cnt_s;
  logic                 full, empty;
  logic [63:0]          item_wide, rd_wide;
  logic [WORD_BITS-1:0] item_w, rd_or;
  logic [WORD_BITS-1:0] word_w [CAPACITY];
  logic [WORD_BITS-1:0] rd_w   [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign pos_s = SlotW'(in_data_i.position);
  assign cnt_s = SlotW'(count_q);
  assign full  = (cnt_s >= CapSlot);
  assign empty = (count_q == '0);

  assign item_wide = {32'b0, in_data_i.item_value};
  assign item_w    = item_wide[WORD_BITS-1:0];

  always_comb begin
    ctl     = '{op: CELL_HOLD, slot: pos_s};
    err     = ERR_OK;
    rd_en   = 1'b0;
    count_n = count_q;
    unique case (in_data_i.command)
      CMD_APPEND: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          ctl     = '{op: CELL_OPEN, slot: cnt_s};
          count_n = CntW'(count_q + 1'b1);
        end
      end
      CMD_INSERT: begin
        if (pos_s > cnt_s) begin
          err = ERR_INDEX;
        end else if (full) begin
          err = ERR_FULL;
        end else begin
          ctl     = '{op: CELL_OPEN, slot: pos_s};
          count_n = CntW'(count_q + 1'b1);
        end
      end
      CMD_PUSH: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          ctl     = '{op: CELL_OPEN, slot: '0};
          count_n = CntW'(count_q + 1'b1);
        end
      end
      CMD_GET, CMD_REPLACE, CMD_REMOVE: begin
        if (empty) begin
          err = ERR_EMPTY;
        end else if (pos_s >= cnt_s) begin
          err = ERR_INDEX;
        end else if (in_data_i.command == CMD_GET) begin
          rd_en = 1'b1;
        end else if (in_data_i.command == CMD_REPLACE) begin
          ctl.op = CELL_WRITE;
        end else begin
          ctl.op  = CELL_CLOSE;
          rd_en   = 1'b1;
          count_n = CntW'(count_q - 1'b1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          ctl     = '{op: CELL_CLOSE, slot: SlotW'(cnt_s - 1'b1)};
          rd_en   = 1'b1;
          count_n = CntW'(count_q - 1'b1);
        end
      end
      default: begin
        err = ERR_OK;
      end
    endcase
    if (!fire) begin
      ctl.op = CELL_HOLD;
    end
  end

  assign count_d = fire ? count_n : count_q;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = word_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = word_w[k+1];
    end
    ils_cell #(
      .INDEX    (k),
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .item_i (item_w),
      .left_i (left_w),
      .right_i(right_w),
      .word_o (word_w[k]),
      .rd_o   (rd_w[k])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      rd_or = rd_or | rd_w[k];
    end
    rd_wide                = '0;
    rd_wide[WORD_BITS-1:0] = rd_or;
  end

  always_comb begin
    out_d            = out_q;
    out_valid_d      = out_valid_q;
    if (fire) begin
      out_d.read_value = rd_en ? rd_wide[31:0] : 32'b0;
      out_d.new_length = 5'(count_n);
      out_d.error_code = err;
      out_valid_d      = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("list length past capacity");

  a_error_keeps_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && err != ERR_OK) |=> count_q == $past(count_q))
    else $error("length changed on a failed command");

  a_open_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ctl.op == CELL_OPEN) |=> count_q == CntW'($past(count_q) + 1'b1))
    else $error("length did not grow on insert");

  a_stall_on_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("word taken while result held");

endmodule
